[src/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and constants for the UTF-8 to UTF-16 transcoder
// Holds the code point constants and the decode result record that passes
// from the byte decoder to the top level and the output queue.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int unsigned MaxUnits = 4;

    localparam logic [15:0] REPLACEMENT   = 16'hFFFD;
    localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
    localparam logic [20:0] SUPP_OFFSET   = 21'h10000;

    // Lead byte prefixes and masks
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;
    localparam logic [1:0] CONT_TAG    = 2'b10;

    // Open sequence state
    typedef struct packed {
        logic [1:0]  needed;
        logic [1:0]  collected;
        logic [20:0] value;
    } t_seq_state;

    // Everything one input byte produces
    typedef struct packed {
        logic [MaxUnits-1:0][15:0] units;
        logic [2:0]                count;
        t_seq_state                next_seq;
    } t_dec_result;

endpackage

[src/u8u16_decode.sv]
// ----------------------------------------------------------------------------
// u8u16_decode: single-byte UTF-8 decode step
// From one byte, the end mark and the open sequence state, form the list of
// UTF-16 units the byte completes and the sequence state that follows.
// ----------------------------------------------------------------------------
module u8u16_decode (
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    input  u8u16_pkg::t_seq_state   i_seq,
    output u8u16_pkg::t_dec_result  o_res
);

    // fresh-byte view
    logic                       f_unit_en;
    logic [15:0]                f_unit;
    logic                       f_open;
    logic [1:0]                 f_need;
    logic [20:0]                f_val;

    // continuation view
    logic                       is_cont;
    logic [20:0]                cont_val;
    logic [2:0]                 got;
    logic [20:0]                off;
    logic [2:0]                 nrep;

    always_comb begin
        f_unit_en = 1'b1;
        f_unit    = u8u16_pkg::REPLACEMENT;
        f_open    = 1'b0;
        f_need    = 2'd0;
        f_val     = '0;
        if (i_byte[7] == 1'b0) begin
            f_unit = {8'h00, i_byte};
        end else if ((i_byte & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE) begin
            f_need = 2'd1;
            f_val  = {16'd0, i_byte[4:0]};
        end else if ((i_byte & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE) begin
            f_need = 2'd2;
            f_val  = {17'd0, i_byte[3:0]};
        end else if ((i_byte & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_CODE) begin
            f_need = 2'd3;
            f_val  = {18'd0, i_byte[2:0]};
        end
        // a valid lead that is also the last byte becomes a replacement
        if (f_need != 2'd0 && !i_last) begin
            f_open    = 1'b1;
            f_unit_en = 1'b0;
        end
    end

    assign is_cont  = (i_byte[7:6] == u8u16_pkg::CONT_TAG);
    assign cont_val = {i_seq.value[14:0], i_byte[5:0]};
    assign got      = {1'b0, i_seq.collected} + 3'd1;
    assign off      = cont_val - u8u16_pkg::SUPP_OFFSET;
    assign nrep     = {1'b0, i_seq.collected} + 3'd1;

    always_comb begin
        o_res.units    = {u8u16_pkg::MaxUnits{u8u16_pkg::REPLACEMENT}};
        o_res.count    = 3'd0;
        o_res.next_seq = '0;
        if (i_seq.needed != 2'd0 && is_cont && got >= {1'b0, i_seq.needed}) begin
            // sequence complete: one unit or a surrogate pair
            if (cont_val[20:16] != 5'd0) begin
                o_res.units[0] = u8u16_pkg::HI_SURR_BASE | {5'd0, off[20:10]};
                o_res.units[1] = u8u16_pkg::LO_SURR_BASE | {6'd0, off[9:0]};
                o_res.count    = 3'd2;
            end else begin
                o_res.units[0] = cont_val[15:0];
                o_res.count    = 3'd1;
            end
        end else if (i_seq.needed != 2'd0 && is_cont && !i_last) begin
            // collect and hold
            o_res.next_seq.needed    = i_seq.needed;
            o_res.next_seq.collected = got[1:0];
            o_res.next_seq.value     = cont_val;
        end else if (i_seq.needed != 2'd0) begin
            // failed sequence: replace lead and taken bytes, then rescan
            o_res.units[nrep[1:0]] = f_unit;
            o_res.count            = nrep + {2'd0, f_unit_en};
            if (f_open) begin
                o_res.next_seq.needed = f_need;
                o_res.next_seq.value  = f_val;
            end
        end else begin
            o_res.units[0] = f_unit;
            o_res.count    = {2'd0, f_unit_en};
            if (f_open) begin
                o_res.next_seq.needed = f_need;
                o_res.next_seq.value  = f_val;
            end
        end
    end

endmodule

[src/u8u16_out_queue.sv]
// ----------------------------------------------------------------------------
// u8u16_out_queue: result register for up to four code units
// Load the units of one byte, present the head unit, shift on each
// downstream transaction, and flag the last unit of the group.
// ----------------------------------------------------------------------------
module u8u16_out_queue (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic [u8u16_pkg::MaxUnits-1:0][15:0] i_units,
    input  logic [2:0]                           i_count,
    output logic                                 o_can_load,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [15:0]                          o_code_unit,
    output logic                                 o_run_end
);

    logic [u8u16_pkg::MaxUnits-1:0][15:0] r_units, n_units;
    logic [2:0]                           r_cnt, n_cnt;
    logic                                 pop;

    assign o_valid     = (r_cnt != 3'd0);
    assign pop         = o_valid && i_ready;
    assign o_can_load  = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_ready);
    assign o_code_unit = r_units[0];
    assign o_run_end   = (r_cnt == 3'd1);

    always_comb begin
        n_units = r_units;
        n_cnt   = r_cnt;
        if (pop) begin
            n_units = {16'd0, r_units[u8u16_pkg::MaxUnits-1:1]};
            n_cnt   = r_cnt - 3'd1;
        end
        if (i_load) begin
            n_units = i_units;
            n_cnt   = i_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_units <= n_units;
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

[src/utf8_to_utf16_transcoder_unit.sv]
// ----------------------------------------------------------------------------
// Timing: a byte's first code unit is offered the cycle after its transaction.
// Throughput: one byte per cycle while the output is ready and each byte yields
//   at most one unit; more units hold the input until the last one is taken.
// Reset: synchronous, active low; clears the open sequence and empties the
//   result register, so no unit is pending afterward.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit: UTF-8 byte stream to UTF-16 code units
// Decode one byte per transaction against the open sequence state, load the
// resulting units into a small result register, draining one per ready cycle.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_string,
    // code unit output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_code_unit,
    output logic        o_run_end
);

    // Open sequence: continuation bytes needed, taken, and bits gathered.
    u8u16_pkg::t_seq_state  r_seq;
    u8u16_pkg::t_dec_result dec;
    logic                   in_accept;
    logic                   can_load;

    // Decode the byte on the port directly; the result lands in the queue
    // register, so only one decode step sits between registers.
    u8u16_decode u_decode (
        .i_byte  (i_in_byte),
        .i_last  (i_end_of_string),
        .i_seq   (r_seq),
        .o_res   (dec)
    );

    // Take a new byte whenever the result register is empty or releases its
    // last unit in this cycle; a byte with no units needs no room at all,
    // but keeping one rule keeps the input ready free of the payload.
    assign o_in_ready = can_load;
    assign in_accept  = i_in_valid && o_in_ready;

    // Advance the sequence state on every transaction. The decoder already
    // drops the state at the end of a string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (in_accept) begin
            r_seq <= dec.next_seq;
        end
    end

    // Hold the units of one byte and hand them out one per transaction.
    u8u16_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_accept && (dec.count != 3'd0)),
        .i_units     (dec.units),
        .i_count     (dec.count),
        .o_can_load  (can_load),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_code_unit (o_code_unit),
        .o_run_end   (o_run_end)
    );

endmodule

[test/utf8_to_utf16_transcoder_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit_tb: self-checking bench for the transcoder
// Feed UTF-8 byte transactions: a directed run over ASCII extremes, every
// lead class, surrogate pairs, invalid leads, bad continuations and early
// string ends, then mostly well-formed random characters mixed with noise
// and broken sequences. A behavioral decoder predicts every UTF-16 code unit
// and its run_end mark, and the monitor compares each output transaction
// against the oldest prediction. Both idle at random in two of three phases.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit_tb;

    localparam int NumItems = 280;
    localparam int PhaseLen = NumItems / 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_utf8_byte;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_end;
    } t_utf16_unit;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_end_of_string = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_code_unit;
    logic        o_run_end;

    t_utf8_byte  utf8_stream[$];     // bytes still to be sent
    t_utf16_unit expected_units[$];  // predicted code units, oldest first
    logic [15:0] staged_units[$];    // units produced by the byte being decoded
    t_utf16_unit oldest_unit;
    int          bytes_taken = 0;
    int          error_count = 0;

    // Open sequence as the decoder sees it
    logic [1:0]  seq_need = 2'd0;
    logic [1:0]  seq_got  = 2'd0;
    logic [20:0] seq_acc  = '0;

    utf8_to_utf16_transcoder_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_code_unit     (o_code_unit),
        .o_run_end       (o_run_end)
    );

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------

    // Treat a byte as the start of something new: ASCII, a lead or garbage.
    function automatic void start_fresh(input logic [7:0] b, input logic last);
        logic [1:0]  need;
        logic [20:0] val;
        need = 2'd0;
        val  = '0;
        if (!b[7]) begin
            staged_units.push_back({8'h00, b});
            return;
        end
        if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE) begin
            need = 2'd1;
            val  = 21'(b[4:0]);
        end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE) begin
            need = 2'd2;
            val  = 21'(b[3:0]);
        end else if ((b & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_CODE) begin
            need = 2'd3;
            val  = 21'(b[2:0]);
        end
        // Invalid leads and a lead that closes the string both fall back to FFFD
        if (need == 2'd0 || last) begin
            staged_units.push_back(u8u16_pkg::REPLACEMENT);
        end else begin
            seq_need = need;
            seq_got  = 2'd0;
            seq_acc  = val;
        end
    endfunction

    // Decode one accepted byte and queue the code units it produces.
    function automatic void decode_utf8_byte(input logic [7:0] b, input logic last);
        logic [20:0] point;
        logic [20:0] offset;
        logic [1:0]  got;
        logic [1:0]  taken;
        logic        failed;
        staged_units.delete();
        failed = 1'b0;
        if (seq_need != 2'd0) begin
            failed = 1'b1;
            if (b[7:6] == u8u16_pkg::CONT_TAG) begin
                point = {seq_acc[14:0], b[5:0]};
                got   = seq_got + 2'd1;
                if (got >= seq_need) begin
                    seq_need = 2'd0;
                    seq_got  = 2'd0;
                    seq_acc  = '0;
                    failed   = 1'b0;
                    if (point <= 21'h00FFFF) begin
                        staged_units.push_back(point[15:0]);
                    end else begin
                        // Split into a surrogate pair, wrapping above 10FFFF
                        offset = point - u8u16_pkg::SUPP_OFFSET;
                        staged_units.push_back(u8u16_pkg::HI_SURR_BASE |
                                               16'(offset[20:10]));
                        staged_units.push_back(u8u16_pkg::LO_SURR_BASE |
                                               16'(offset[9:0]));
                    end
                end else if (!last) begin
                    seq_got = got;
                    seq_acc = point;
                    return;
                end
            end
            if (failed) begin
                // One FFFD for the lead, one per buffered continuation, then rescan
                taken    = seq_got;
                seq_need = 2'd0;
                seq_got  = 2'd0;
                seq_acc  = '0;
                staged_units.push_back(u8u16_pkg::REPLACEMENT);
                for (int i = 0; i < taken && i < 2; i++) begin
                    staged_units.push_back(u8u16_pkg::REPLACEMENT);
                end
                start_fresh(b, last);
            end
        end else begin
            start_fresh(b, last);
        end

        if (last) begin
            seq_need = 2'd0;
            seq_got  = 2'd0;
            seq_acc  = '0;
        end
        for (int i = 0; i < staged_units.size() && i < u8u16_pkg::MaxUnits; i++) begin
            expected_units.push_back('{code_unit: staged_units[i],
                                       run_end: (i == staged_units.size() - 1)});
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver: present queued bytes, hold each until its transaction completes
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // Predict on the transaction itself, using the pre-edge payload
            if (i_in_valid && o_in_ready) begin
                decode_utf8_byte(i_in_byte, i_end_of_string);
                bytes_taken++;
            end
            // Advance only once the current byte is gone; never drop valid early
            if (!i_in_valid || o_in_ready) begin
                if (utf8_stream.size() > 0 &&
                    $urandom_range(99) >= ((bytes_taken < PhaseLen)     ? 16 :
                                           (bytes_taken < 2 * PhaseLen) ? 87 : 0)) begin
                    i_in_valid      <= 1'b1;
                    i_in_byte       <= utf8_stream[0].in_byte;
                    i_end_of_string <= utf8_stream[0].end_of_string;
                    void'(utf8_stream.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each output transaction and throttle ready
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_units.size() == 0) begin
                $error("unexpected code unit %h (run_end %b)", o_code_unit, o_run_end);
                error_count++;
            end else begin
                oldest_unit = expected_units.pop_front();
                if (o_code_unit !== oldest_unit.code_unit) begin
                    $error("code_unit: expected %h, actual %h",
                           oldest_unit.code_unit, o_code_unit);
                    error_count++;
                end
                if (o_run_end !== oldest_unit.run_end) begin
                    $error("run_end: expected %b, actual %b",
                           oldest_unit.run_end, o_run_end);
                    error_count++;
                end
            end
        end
        // Receiver stalls: heavy first, light next, none at the end
        i_out_ready <= ($urandom_range(99) >= ((bytes_taken < PhaseLen)     ? 87 :
                                               (bytes_taken < 2 * PhaseLen) ? 16 : 0));
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic eos);
        utf8_stream.push_back('{in_byte: b, end_of_string: eos});
    endtask

    initial begin : stimulus
        int         kind;
        int         char_len;
        logic [7:0] char_bytes [4];

        i_rst_n = 1'b0;

        // ASCII extremes; zero byte does not end the string
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b1);
        // Three-byte character (euro sign)
        push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'hAC, 1'b0);
        // Four-byte character, emitted as a surrogate pair
        push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0);
        push_byte(8'h98, 1'b0); push_byte(8'h80, 1'b0);
        // Largest value the F7 lead can reach, beyond 10FFFF, ending the string
        push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b1);
        // Invalid leads: stray continuation and FF
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        // Bad continuation after one buffered byte; ASCII is rescanned
        push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'h41, 1'b0);
        // Two-byte lead as last byte
        push_byte(8'hC3, 1'b1);
        // String ends on an incomplete continuation
        push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);
        // Two buffered continuations then a bad byte: four units from one byte
        push_byte(8'hF0, 1'b0); push_byte(8'h90, 1'b0);
        push_byte(8'h80, 1'b0); push_byte(8'h41, 1'b1);

        // Random part: mostly well-formed characters, some noise and breakage
        while (utf8_stream.size() < NumItems) begin
            kind = $urandom_range(9);
            if (kind <= 1) begin
                char_len      = 1;
                char_bytes[0] = 8'($urandom_range(127));
            end else if (kind == 8) begin
                char_len      = 1;
                char_bytes[0] = 8'($urandom_range(255));
            end else begin
                char_len = $urandom_range(2, 4);
                case (char_len)
                    2:       char_bytes[0] = u8u16_pkg::LEAD2_CODE | 8'($urandom_range(31));
                    3:       char_bytes[0] = u8u16_pkg::LEAD3_CODE | 8'($urandom_range(15));
                    default: char_bytes[0] = u8u16_pkg::LEAD4_CODE | 8'($urandom_range(7));
                endcase
                for (int i = 1; i < char_len; i++) begin
                    char_bytes[i] = 8'h80 | 8'($urandom_range(63));
                end
                if (kind == 9) begin
                    // Break it: truncate, or replace a continuation with any byte
                    if ($urandom_range(1) == 0) begin
                        char_len = $urandom_range(1, char_len - 1);
                    end else begin
                        char_bytes[$urandom_range(1, char_len - 1)] = 8'($urandom_range(255));
                    end
                end
            end
            for (int i = 0; i < char_len; i++) begin
                push_byte(char_bytes[i], (i == char_len - 1) ? ($urandom_range(7) == 0)
                                                              : ($urandom_range(39) == 0));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hold until every byte has completed its transaction
        do @(posedge i_clk); while (utf8_stream.size() > 0 || i_in_valid);
        // Drain the predictions, then watch for stray units
        do @(posedge i_clk); while (expected_units.size() > 0);
        repeat (10) @(posedge i_clk);

        if (error_count == 0 && expected_units.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
src/u8u16_pkg.sv
src/u8u16_decode.sv
src/u8u16_out_queue.sv
src/utf8_to_utf16_transcoder_unit.sv
test/utf8_to_utf16_transcoder_unit_tb.sv
